// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Holds the action and status codes, the slot type and the broadcast command
// that drives the row of queue cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRI_W  = 16;
    localparam int OCC_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [PRI_W-1:0]  pri;
    } spq_slot_t;

    // One command per cycle, seen by every cell at once.
    typedef struct packed {
        logic      ins;
        logic      rem;
        spq_slot_t entry;
    } spq_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, flags whether a new entry belongs at or before this slot,
// and on each command takes the new entry, its left or its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic               aclk,
    input  spq_pkg::spq_cmd_t  cmd,
    input  logic               occupied,
    input  logic               left_before,
    input  spq_pkg::spq_slot_t left_slot,
    input  spq_pkg::spq_slot_t right_slot,
    output logic               ins_here,
    output spq_pkg::spq_slot_t slot
);
    import spq_pkg::*;

    spq_slot_t slot_reg;
    spq_slot_t slot_next;
    logic      pri_hit;

    // The head takes a new entry of equal priority in front of itself; every
    // other slot keeps equal priorities ahead of the new entry.
    assign pri_hit = IS_HEAD ? (cmd.entry.pri <= slot_reg.pri)
                             : (slot_reg.pri > cmd.entry.pri);
    // The flag ripples down the row, so every slot behind the insert point
    // shifts even when its own priority ties with the new entry.
    assign ins_here = left_before || !occupied || pri_hit;

    always_comb begin
        slot_next = slot_reg;
        if (cmd.ins) begin
            if (left_before) begin
                slot_next = left_slot;
            end else if (ins_here) begin
                slot_next = cmd.entry;
            end
        end else if (cmd.rem) begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue in a row of cells
// Entries are held sorted by ascending priority, slot 0 is the head. An
// insert shifts the tail right and drops the new entry in place; a remove
// shifts every slot left and returns the old head.
//
//   Channel  Direction  tdata (low bit up)                     tuser
//   s_       in         item_data, item_priority               action
//   m_       out        head_data, head_priority, occupancy    status
//
// One word is taken per cycle while s_tready is high; its result is registered and appears in the next cycle.
// Every cell compares its priority with the incoming one in parallel, so
// the whole row shifts together.
// A result word waiting in the output register blocks input only while
// m_tready is low; taking it frees the input in the same cycle.
// Reset clears the entry count and the output valid; slots need no clear.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_data[31:0], item_priority[47:32]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // head_data[31:0], head_priority[47:32],
                                   // occupancy[52:48]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    spq_status_t      status_reg;
    spq_slot_t        head_reg;
    logic [OCC_W-1:0] occ_reg;

    logic             accept;
    logic             is_remove;
    logic             full;
    logic             empty;
    spq_status_t      status_next;
    spq_cmd_t         cmd;
    logic [CNT_W+OCC_W-1:0] count_ext;

    spq_slot_t        slot_q   [QUEUE_DEPTH];
    logic             before_q [QUEUE_DEPTH];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (s_tuser[0] == ACT_REMOVE);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    always_comb begin
        cmd.entry.data = s_tdata[31:0];
        cmd.entry.pri  = s_tdata[47:32];
        cmd.ins        = accept && !is_remove && !full;
        cmd.rem        = accept && is_remove && !empty;
        count_next     = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (is_remove) begin
            status_next = empty ? ST_EMPTY : ST_REMOVED;
        end else begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic      left_before;
            spq_slot_t left_slot;
            spq_slot_t right_slot;

            if (gi == 0) begin : g_first
                assign left_before = 1'b0;
                assign left_slot   = cmd.entry;
            end else begin : g_mid
                assign left_before = before_q[gi-1];
                assign left_slot   = slot_q[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign right_slot = slot_q[gi];
            end else begin : g_inner
                assign right_slot = slot_q[gi+1];
            end

            spq_cell #(
                .IS_HEAD (gi == 0)
            ) u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_before (left_before),
                .left_slot   (left_slot),
                .right_slot  (right_slot),
                .ins_here    (before_q[gi]),
                .slot        (slot_q[gi])
            );
        end
    endgenerate

    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The result word carries the old head only on a real remove.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            occ_reg    <= count_ext[OCC_W-1:0];
            if (cmd.rem) begin
                head_reg <= slot_q[0];
            end else begin
                head_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, head_reg.pri, head_reg.data};

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_insert_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the entry count");

    a_head_sorted : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (slot_q[0].pri <= slot_q[1].pri))
        else $error("head entry out of order");

    a_empty_status : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_remove && empty) |=> (m_tvalid && m_tuser == ST_EMPTY))
        else $error("remove on empty queue not reported");

endmodule
